// File: hw/rtl/clkh_pkg.sv
// Shared types and constants for the clock hand frame generator.
// Used by the top level, the color scaling unit and the port checker.
package clkh_pkg;

  localparam int unsigned NUM_LEDS_DEF = 60;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned NUM_HANDS    = 3;

  localparam int unsigned HAND_HOUR    = 0;
  localparam int unsigned HAND_MINUTE  = 1;
  localparam int unsigned HAND_SECOND  = 2;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x <= 255 * 127
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int unsigned RECIP_SHIFT  = 19;

  localparam logic [6:0]  BRIGHTNESS_RST   = 7'd25;
  localparam logic        SHOW_SECONDS_RST = 1'b1;
  localparam logic        DISPLAY_ON_RST   = 1'b1;
  localparam logic [23:0] HOUR_COLOR_RST   = 24'hFF0000;
  localparam logic [23:0] MINUTE_COLOR_RST = 24'h00FF00;
  localparam logic [23:0] SECOND_COLOR_RST = 24'h0000FF;

  typedef enum logic [2:0] {
    REG_BRIGHTNESS   = 3'd0,
    REG_SHOW_SECONDS = 3'd1,
    REG_DISPLAY_ON   = 3'd2,
    REG_HOUR_COLOR   = 3'd3,
    REG_MINUTE_COLOR = 3'd4,
    REG_SECOND_COLOR = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// File: hw/rtl/clkh_scale.sv
// Brightness scaling of the three hand colors, two register stages.
// Depends on clkh_pkg (rgb_t, reciprocal constants).
module clkh_scale (
  input  logic                                  clk_i,
  input  logic [6:0]                            brightness_i,
  input  logic [clkh_pkg::NUM_HANDS-1:0][23:0]  color_i,
  output clkh_pkg::rgb_t [clkh_pkg::NUM_HANDS-1:0] scaled_o
);
  import clkh_pkg::*;

  logic [NUM_HANDS-1:0][2:0][14:0] prod_d, prod_q;
  logic [NUM_HANDS-1:0][2:0][27:0] quo;
  logic [NUM_HANDS-1:0][2:0][7:0]  chan;
  rgb_t [NUM_HANDS-1:0]            scaled_d, scaled_q;

  always_comb begin
    for (int h = 0; h < NUM_HANDS; h++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[h][c] = 15'(color_i[h][8*c +: 8]) * 15'(brightness_i);
      end
    end
  end

  always_comb begin
    for (int h = 0; h < NUM_HANDS; h++) begin
      for (int c = 0; c < 3; c++) begin
        quo[h][c]  = 28'(prod_q[h][c]) * 28'(RECIP_100);
        chan[h][c] = quo[h][c][RECIP_SHIFT+8] ? 8'hFF
                                              : quo[h][c][RECIP_SHIFT+7:RECIP_SHIFT];
      end
      scaled_d[h] = {chan[h][2], chan[h][1], chan[h][0]};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    scaled_q <= scaled_d;
  end

  assign scaled_o = scaled_q;

endmodule

// File: hw/rtl/clock_hand_frame_generator.sv
// Clock hand frame generator: one time transaction in, one frame of NumLeds pixels out.
// The first pixel of a frame passes through the sequencer register and pipe stages 1, 2 and 3 before it is valid.
// Throughput: one pixel per cycle while out_stall_i does not hold the pipe; the next time transaction is
// accepted in the cycle the previous frame issues its last pixel into the 3-stage pixel pipe.
// Reset (rst_ni low, async): pipe valids clear, configuration registers return to their reset values.
// Depends on clkh_pkg and clkh_scale.
module clock_hand_frame_generator #(
  parameter int unsigned NumLeds = clkh_pkg::NUM_LEDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clkh_pkg::ADDR_W-1:0]   paddr,
  input  logic [clkh_pkg::DATA_W-1:0]   pwdata,
  output logic [clkh_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [4:0]                    hour_i,
  input  logic [5:0]                    minute_i,
  input  logic [5:0]                    second_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [clkh_pkg::IDX_W-1:0]    led_index_o,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic                          last_o
);
  import clkh_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NumLeds - 1);
  localparam logic [IDX_W:0]   RingLen = (IDX_W+1)'(NumLeds);

  // configuration registers
  logic [6:0]  brightness_q;
  logic        show_seconds_q, display_on_q;
  logic [23:0] hour_color_q, minute_color_q, second_color_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q   <= BRIGHTNESS_RST;
      show_seconds_q <= SHOW_SECONDS_RST;
      display_on_q   <= DISPLAY_ON_RST;
      hour_color_q   <= HOUR_COLOR_RST;
      minute_color_q <= MINUTE_COLOR_RST;
      second_color_q <= SECOND_COLOR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BRIGHTNESS:   brightness_q   <= pwdata[6:0];
        REG_SHOW_SECONDS: show_seconds_q <= pwdata[0];
        REG_DISPLAY_ON:   display_on_q   <= pwdata[0];
        REG_HOUR_COLOR:   hour_color_q   <= pwdata[23:0];
        REG_MINUTE_COLOR: minute_color_q <= pwdata[23:0];
        REG_SECOND_COLOR: second_color_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BRIGHTNESS:   prdata = DATA_W'(brightness_q);
      REG_SHOW_SECONDS: prdata = DATA_W'(show_seconds_q);
      REG_DISPLAY_ON:   prdata = DATA_W'(display_on_q);
      REG_HOUR_COLOR:   prdata = DATA_W'(hour_color_q);
      REG_MINUTE_COLOR: prdata = DATA_W'(minute_color_q);
      REG_SECOND_COLOR: prdata = DATA_W'(second_color_q);
      default:          prdata = '0;
    endcase
  end

  // scaled hand colors, follow the registers through the prod_q and scaled_q registers of clkh_scale
  rgb_t [NUM_HANDS-1:0]        scaled;
  logic [NUM_HANDS-1:0][23:0]  colors;

  assign colors[HAND_HOUR]   = hour_color_q;
  assign colors[HAND_MINUTE] = minute_color_q;
  assign colors[HAND_SECOND] = second_color_q;

  clkh_scale u_scale (
    .clk_i       (clk_i),
    .brightness_i(brightness_q),
    .color_i     (colors),
    .scaled_o    (scaled)
  );

  // hand positions of the incoming transaction
  logic [3:0]       hour12;
  logic [IDX_W:0]   hour_off, min_red, sec_red;
  logic [IDX_W-1:0] hour_pos, min_pos, sec_pos;

  always_comb begin
    if (hour_i >= 5'd24) begin
      hour12 = 4'(hour_i - 5'd24);
    end else if (hour_i >= 5'd12) begin
      hour12 = 4'(hour_i - 5'd12);
    end else begin
      hour12 = hour_i[3:0];
    end
    hour_off = (IDX_W+1)'({hour12, 2'b00}) + (IDX_W+1)'(hour12);
    min_red  = ({1'b0, minute_i} >= RingLen) ? {1'b0, minute_i} - RingLen : {1'b0, minute_i};
    sec_red  = ({1'b0, second_i} >= RingLen) ? {1'b0, second_i} - RingLen : {1'b0, second_i};
    hour_pos = (hour_off == '0) ? '0 : IDX_W'(RingLen - hour_off);
    min_pos  = (min_red == '0)  ? '0 : IDX_W'(RingLen - min_red);
    sec_pos  = (sec_red == '0)  ? '0 : IDX_W'(RingLen - sec_red);
  end

  // frame sequencer and pixel pipe handshake
  logic             item_v_q;
  logic [IDX_W-1:0] idx_q, hp_q, mp_q, sp_q;
  logic             s1_v_q, s2_v_q, s3_v_q;
  logic             s1_rdy, s2_rdy, s3_rdy;
  logic             issue, item_done, in_acc;

  assign s3_rdy     = !s3_v_q || !out_stall_i;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign issue      = item_v_q && s1_rdy;
  assign item_done  = issue && (idx_q == LastIdx);
  assign in_stall_o = item_v_q && !item_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (in_acc) begin
        item_v_q <= 1'b1;
        idx_q    <= '0;
      end else if (issue) begin
        item_v_q <= !item_done;
        idx_q    <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hp_q <= hour_pos;
      mp_q <= min_pos;
      sp_q <= sec_pos;
    end
  end

  // stage 1: hand hits
  logic [IDX_W-1:0]     s1_idx_q;
  logic                 s1_last_q;
  logic [NUM_HANDS-1:0] s1_hit_q, s1_hit_d;

  always_comb begin
    s1_hit_d[HAND_HOUR]   = display_on_q && (idx_q == hp_q);
    s1_hit_d[HAND_MINUTE] = display_on_q && (idx_q == mp_q);
    s1_hit_d[HAND_SECOND] = display_on_q && show_seconds_q && (idx_q == sp_q);
  end

  // stage 2: channel sums, stage 3: saturation into the output register
  logic [IDX_W-1:0] s2_idx_q;
  logic             s2_last_q;
  logic [2:0][9:0]  s2_sum_q, s2_sum_d;
  rgb_t             pick [NUM_HANDS];
  logic [IDX_W-1:0] s3_idx_q;
  logic             s3_last_q;
  rgb_t             s3_pix_q, s3_pix_d;

  always_comb begin
    for (int h = 0; h < NUM_HANDS; h++) begin
      pick[h] = s1_hit_q[h] ? scaled[h] : '0;
    end
    s2_sum_d[2] = 10'(pick[0].red)   + 10'(pick[1].red)   + 10'(pick[2].red);
    s2_sum_d[1] = 10'(pick[0].green) + 10'(pick[1].green) + 10'(pick[2].green);
    s2_sum_d[0] = 10'(pick[0].blue)  + 10'(pick[1].blue)  + 10'(pick[2].blue);
    s3_pix_d.red   = (s2_sum_q[2] > 10'd255) ? 8'hFF : s2_sum_q[2][7:0];
    s3_pix_d.green = (s2_sum_q[1] > 10'd255) ? 8'hFF : s2_sum_q[1][7:0];
    s3_pix_d.blue  = (s2_sum_q[0] > 10'd255) ? 8'hFF : s2_sum_q[0][7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= issue;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q  <= idx_q;
      s1_last_q <= (idx_q == LastIdx);
      s1_hit_q  <= s1_hit_d;
    end
    if (s2_rdy && s1_v_q) begin
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
      s2_sum_q  <= s2_sum_d;
    end
    if (s3_rdy && s2_v_q) begin
      s3_idx_q  <= s2_idx_q;
      s3_last_q <= s2_last_q;
      s3_pix_q  <= s3_pix_d;
    end
  end

  assign out_valid_o = s3_v_q;
  assign led_index_o = s3_idx_q;
  assign red_o       = s3_pix_q.red;
  assign green_o     = s3_pix_q.green;
  assign blue_o      = s3_pix_q.blue;
  assign last_o      = s3_last_q;

endmodule

// File: hw/rtl/clkh_checker.sv
// Port-level checks on the pixel output of the clock hand frame generator.
// Depends on clkh_pkg; bound to clock_hand_frame_generator at the end of this file.
module clkh_checker #(
  parameter int unsigned NumLeds = clkh_pkg::NUM_LEDS_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [clkh_pkg::IDX_W-1:0] led_index_o,
  input logic [7:0]                 red_o,
  input logic [7:0]                 green_o,
  input logic [7:0]                 blue_o,
  input logic                       last_o
);
  import clkh_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NumLeds - 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(led_index_o) && $stable(red_o)
      && $stable(green_o) && $stable(blue_o) && $stable(last_o))
    else $error("stalled pixel transaction changed");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (led_index_o == LastIdx)))
    else $error("last marker not on final ring position");

  a_frame_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && (led_index_o == $past(led_index_o) + IDX_W'(1)))
    else $error("frame pixels not contiguous");

  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind clock_hand_frame_generator clkh_checker #(.NumLeds(NumLeds)) u_clkh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .led_index_o(led_index_o),
  .red_o      (red_o),
  .green_o    (green_o),
  .blue_o     (blue_o),
  .last_o     (last_o)
);

// File: bench/tb_clock_hand_frame_generator.sv
// Testbench for clock_hand_frame_generator: directed table, then randomized time transactions.
// Frames are checked pixel by pixel against an in-bench model of the hand drawing or a typed frame.
// Depends on clkh_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_clock_hand_frame_generator;
  import clkh_pkg::*;

  localparam int unsigned NUM_LEDS      = NUM_LEDS_DEF;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned WATCHDOG_MAX  = 4000;
  localparam int unsigned MAX_PRINT     = 40;
  localparam int unsigned RAND_BLOCKS   = 12;
  localparam int unsigned BLOCK_ITEMS   = 40;
  localparam int unsigned DIR_ROWS      = 29;
  localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

  typedef enum logic {ROW_TIME, ROW_CFG} row_kind_e;
  typedef enum logic {CHK_PRED, CHK_TYPED} chk_e;

  typedef struct packed {
    logic [5:0] idx;
    rgb_t       rgb;
    logic       last;
  } pixel_t;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  sel;
    logic [31:0] data;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    chk_e        chk;
    logic [5:0]  idx;
    rgb_t        rgb;
  } dir_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [4:0]        hour_i      = '0;
  logic [5:0]        minute_i    = '0;
  logic [5:0]        second_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [IDX_W-1:0]  led_index_o;
  logic [7:0]        red_o;
  logic [7:0]        green_o;
  logic [7:0]        blue_o;
  logic              last_o;

  clock_hand_frame_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .hour_i      (hour_i),
    .minute_i    (minute_i),
    .second_i    (second_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_index_o (led_index_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // register shadow
  logic [6:0] cfg_bright;
  logic       cfg_show;
  logic       cfg_disp;
  rgb_t       cfg_hour_rgb;
  rgb_t       cfg_min_rgb;
  rgb_t       cfg_sec_rgb;

  pixel_t      pixel_q [$];
  int unsigned mismatch_cnt  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_TIME, 3'd0, 32'd0, 5'd0,  6'd0,  6'd0,  CHK_TYPED, 6'd0,  24'h3F3F3F},
    '{ROW_TIME, 3'd0, 32'd0, 5'd12, 6'd0,  6'd0,  CHK_TYPED, 6'd0,  24'h3F3F3F},
    '{ROW_TIME, 3'd0, 32'd0, 5'd9,  6'd45, 6'd45, CHK_TYPED, 6'd15, 24'h3F3F3F},
    '{ROW_TIME, 3'd0, 32'd0, 5'd31, 6'd63, 6'd63, CHK_PRED,  6'd0,  24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd23, 6'd59, 6'd59, CHK_PRED,  6'd0,  24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd3,  6'd20, 6'd40, CHK_PRED,  6'd0,  24'h0},
    '{ROW_CFG,  REG_BRIGHTNESS,   32'd100,       5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd0,  6'd0,  6'd0,  CHK_TYPED, 6'd0,  24'hFFFFFF},
    '{ROW_TIME, 3'd0, 32'd0, 5'd6,  6'd30, 6'd30, CHK_TYPED, 6'd30, 24'hFFFFFF},
    '{ROW_CFG,  REG_BRIGHTNESS,   32'hFFFF_FFFF, 5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd7,  6'd1,  6'd2,  CHK_PRED,  6'd0,  24'h0},
    '{ROW_CFG,  REG_HOUR_COLOR,   32'hFF12_3456, 5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_CFG,  REG_MINUTE_COLOR, 32'h00FF_FFFF, 5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_CFG,  REG_SECOND_COLOR, 32'h0000_0000, 5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd1,  6'd5,  6'd5,  CHK_PRED,  6'd0,  24'h0},
    '{ROW_CFG,  REG_BRIGHTNESS,   32'd0,         5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd2,  6'd10, 6'd10, CHK_TYPED, 6'd0,  24'h0},
    '{ROW_CFG,  REG_BRIGHTNESS,   32'd50,        5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_CFG,  REG_SHOW_SECONDS, 32'd0,         5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd4,  6'd20, 6'd40, CHK_PRED,  6'd0,  24'h0},
    '{ROW_CFG,  REG_DISPLAY_ON,   32'd0,         5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd5,  6'd25, 6'd50, CHK_TYPED, 6'd0,  24'h0},
    '{ROW_CFG,  REG_SPARE_LO,     32'hFFFF_FFFF, 5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_CFG,  REG_SPARE_HI,     32'hFFFF_FFFF, 5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd0,  6'd0,  6'd0,  CHK_TYPED, 6'd0,  24'h0},
    '{ROW_CFG,  REG_DISPLAY_ON,   32'd1,         5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_CFG,  REG_SHOW_SECONDS, 32'd1,         5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_CFG,  REG_SECOND_COLOR, 32'h0000_00FF, 5'd0, 6'd0, 6'd0, CHK_PRED, 6'd0, 24'h0},
    '{ROW_TIME, 3'd0, 32'd0, 5'd8,  6'd33, 6'd17, CHK_PRED,  6'd0,  24'h0}
  };

  function automatic logic [7:0] scale_chan(logic [7:0] c);
    int unsigned v;
    v = (int'(c) * int'(cfg_bright)) / 100;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [7:0] sat_add(logic [7:0] a, logic [7:0] c);
    int unsigned t;
    t = int'(a) + int'(scale_chan(c));
    return (t > 255) ? 8'hFF : t[7:0];
  endfunction

  function automatic rgb_t add_hand(rgb_t px, rgb_t col);
    rgb_t sum;
    sum.red   = sat_add(px.red,   col.red);
    sum.green = sat_add(px.green, col.green);
    sum.blue  = sat_add(px.blue,  col.blue);
    return sum;
  endfunction

  function automatic int unsigned ring_pos(int unsigned v);
    return (NUM_LEDS - (v % NUM_LEDS)) % NUM_LEDS;
  endfunction

  // expected frame for one time transaction under the current registers
  function automatic void queue_frame(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    rgb_t        frame [NUM_LEDS];
    int unsigned hp;
    int unsigned mp;
    int unsigned sp;
    pixel_t      p;
    hp = ring_pos((int'(h) % 12) * 5);
    mp = ring_pos(int'(m));
    sp = ring_pos(int'(s));
    for (int i = 0; i < NUM_LEDS; i++) frame[i] = '0;
    if (cfg_disp) begin
      if (cfg_show) frame[sp] = add_hand(frame[sp], cfg_sec_rgb);
      frame[mp] = add_hand(frame[mp], cfg_min_rgb);
      frame[hp] = add_hand(frame[hp], cfg_hour_rgb);
    end
    for (int i = 0; i < NUM_LEDS; i++) begin
      p.idx  = i[5:0];
      p.rgb  = frame[i];
      p.last = (i == NUM_LEDS - 1);
      pixel_q.push_back(p);
    end
  endfunction

  // frame with at most one lit pixel, typed in by hand
  function automatic void queue_typed(logic [5:0] lit_idx, rgb_t lit_rgb);
    pixel_t p;
    for (int i = 0; i < NUM_LEDS; i++) begin
      p.idx  = i[5:0];
      p.rgb  = (i == lit_idx) ? lit_rgb : rgb_t'(0);
      p.last = (i == NUM_LEDS - 1);
      pixel_q.push_back(p);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_cnt < MAX_PRINT)
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // pixel checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel at index", 32'(led_index_o), 0);
      end else begin
        want = pixel_q.pop_front();
        if (led_index_o != want.idx)
          report_mismatch("led_index", 32'(led_index_o), 32'(want.idx));
        if (red_o != want.rgb.red)
          report_mismatch("red", 32'(red_o), 32'(want.rgb.red));
        if (green_o != want.rgb.green)
          report_mismatch("green", 32'(green_o), 32'(want.rgb.green));
        if (blue_o != want.rgb.blue)
          report_mismatch("blue", 32'(blue_o), 32'(want.rgb.blue));
        if (last_o != want.last)
          report_mismatch("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("tb_clock_hand_frame_generator: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (sel)
      REG_BRIGHTNESS:   cfg_bright   = data[6:0];
      REG_SHOW_SECONDS: cfg_show     = data[0];
      REG_DISPLAY_ON:   cfg_disp     = data[0];
      REG_HOUR_COLOR:   cfg_hour_rgb = data[23:0];
      REG_MINUTE_COLOR: cfg_min_rgb  = data[23:0];
      REG_SECOND_COLOR: cfg_sec_rgb  = data[23:0];
      default: ;
    endcase
  endtask

  task automatic send_time(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s,
                           input chk_e chk, input logic [5:0] lit_idx, input rgb_t lit_rgb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hour_i     <= h;
    minute_i   <= m;
    second_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    if (chk == CHK_TYPED) queue_typed(lit_idx, lit_rgb);
    else queue_frame(h, m, s);
  endtask

  function automatic logic [23:0] pick_color();
    case ($urandom_range(0, 3))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_config();
    logic [6:0]  b;
    logic [31:0] noise;
    case ($urandom_range(0, 5))
      0:       b = 7'd0;
      1:       b = 7'd100;
      2:       b = 7'd127;
      default: b = 7'($urandom_range(0, 127));
    endcase
    noise = $urandom();
    wait_drained();
    write_reg(REG_BRIGHTNESS,   (noise & 32'hFFFF_FF80) | b);
    write_reg(REG_SHOW_SECONDS, $urandom());
    write_reg(REG_DISPLAY_ON,   (noise & 32'hFFFF_FFFE) | ($urandom_range(0, 5) != 0));
    write_reg(REG_HOUR_COLOR,   {noise[31:24], pick_color()});
    write_reg(REG_MINUTE_COLOR, {noise[23:16], pick_color()});
    write_reg(REG_SECOND_COLOR, {noise[15:8], pick_color()});
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
  endtask

  initial begin
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
    cfg_bright   = BRIGHTNESS_RST;
    cfg_show     = SHOW_SECONDS_RST;
    cfg_disp     = DISPLAY_ON_RST;
    cfg_hour_rgb = HOUR_COLOR_RST;
    cfg_min_rgb  = MINUTE_COLOR_RST;
    cfg_sec_rgb  = SECOND_COLOR_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 29;
    recv_idle_pct = 45;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_tab[r].sel, dir_tab[r].data);
      end else begin
        send_time(dir_tab[r].hour, dir_tab[r].minute, dir_tab[r].second,
                  dir_tab[r].chk, dir_tab[r].idx, dir_tab[r].rgb);
      end
    end

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      if (blk < 4) begin
        send_idle_pct = 29;
        recv_idle_pct = 45;
      end else if (blk < 8) begin
        send_idle_pct = 45;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config();
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          7: begin
            // hands stacked on one LED
            h = 5'($urandom_range(0, 23));
            m = 6'((int'(h) % 12) * 5);
            s = $urandom_range(0, 1) ? m : 6'($urandom_range(0, 59));
          end
          8, 9: begin
            h = 5'($urandom_range(0, 31));
            m = 6'($urandom_range(0, 63));
            s = 6'($urandom_range(0, 63));
          end
          default: begin
            h = 5'($urandom_range(0, 23));
            m = 6'($urandom_range(0, 59));
            s = 6'($urandom_range(0, 59));
          end
        endcase
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_time(h, m, s, CHK_PRED, 6'd0, rgb_t'(0));
      end
    end

    wait_drained();
    if (mismatch_cnt == 0)
      $display("tb_clock_hand_frame_generator: done, clean");
    else
      $display("tb_clock_hand_frame_generator: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/clkh_pkg.sv
hw/rtl/clkh_scale.sv
hw/rtl/clock_hand_frame_generator.sv
hw/rtl/clkh_checker.sv
bench/tb_clock_hand_frame_generator.sv
